### hw/rtl/assert_macros.svh
// assertion macros shared by the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define I2P_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define I2P_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/i2p_pkg.sv
// shared constants, status codes and character helpers of the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int CHAR_W          = 8;
	localparam int LIMIT_W         = 6;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

	// status reported on every result of an item
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_UNMATCHED = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	// operator precedence, zero for anything that is not an operator
	function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
		logic [1:0] p;
		case (c) inside
			CH_PLUS, CH_MINUS: p = 2'd1;
			CH_MUL, CH_DIV:    p = 2'd2;
			CH_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	// ascii letter in either case
	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

endpackage

### hw/rtl/i2p_stack_ram.sv
// operator stack storage: one write port, one registered read port
`timescale 1ns / 1ps

module i2p_stack_ram #(
	parameter int DEPTH = i2p_pkg::STACK_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [i2p_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [i2p_pkg::CHAR_W-1:0] rdata
);

	logic [i2p_pkg::CHAR_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/infix_to_postfix_converter.sv
// infix to postfix converter: top level with operator stack sequencer
// Usage: one infix character per input item on in_valid/in_ready, with
// end_of_expr set on the last character of an expression. Each item yields
// one or more result items on out_valid/out_ready: one per emitted postfix
// character, or a single status-only item when nothing is emitted. The last
// result of an item carries last_of_run, and expr_done when it ended an
// expression. status is the same on every result of the item.
// The stack limit is written on cfg_valid/cfg_ready (always ready); the user is to
// write it only while idle, the block itself does not enforce it. Each item is
// accepted, dispatched and finished, with a pop loop that pops one stack entry
// per step; an operator, a ')' with no matching '(' and an end of expression each
// add a step that closes their pop loop. An operator that meets a stack at or above
// its limit first runs a read-only scan over the entries it would pop, and an end
// of expression right after a push adds a settle step for the stack read to settle.
// Every step is paced by the single read port of the stack memory.
// A result waits in the output register while the receiver stalls; the
// sequencer then holds, and the next item is accepted once the last result of
// the current one sits in the output register.
// Reset empties the stack, clears the output valid and sets the limit to 32.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [i2p_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [i2p_pkg::CHAR_W-1:0]  in_char,
	input  logic                        end_of_expr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [i2p_pkg::CHAR_W-1:0]  out_char,
	output logic                        char_valid,
	output logic                        last_of_run,
	output logic [1:0]                  status,
	output logic                        expr_done
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = (CW > i2p_pkg::LIMIT_W) ? CW : i2p_pkg::LIMIT_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DISP   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_SETTLE = 6'b001000,
		S_POP    = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PM_OP    = 2'd0,
		PM_RPAR  = 2'd1,
		PM_FLUSH = 2'd2
	} pop_mode_t;

	state_t                     state_q, state_d;
	pop_mode_t                  mode_q, mode_d;
	i2p_pkg::status_t           st_q, st_d;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic [CW-1:0]              paren_q, paren_d;
	logic [CW-1:0]              sp_q, sp_d;
	logic [i2p_pkg::LIMIT_W-1:0] lim_q;
	logic [i2p_pkg::CHAR_W-1:0] c_q;
	logic                       end_q;
	logic [i2p_pkg::CHAR_W-1:0] hold_q;
	logic                       hold_v_q;
	logic                       out_valid_q;
	logic [i2p_pkg::CHAR_W-1:0] out_char_q;
	logic                       char_valid_q, last_q, done_q;
	logic [1:0]                 status_q;

	logic [EW-1:0]              lim_ext, eff_ext;
	logic [CW-1:0]              eff_lim, cnt_m1, cnt_m2, sp_m2;
	logic [AW-1:0]              rd_addr;
	logic [i2p_pkg::CHAR_W-1:0] rd_data, emit_c;
	logic [1:0]                 top_prec, c_prec;
	logic                       we, emit, fin, out_free, can_emit, in_acc;

	// stack memory
	i2p_stack_ram #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (c_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// effective limit: zero acts as one, capped at the stack depth
	always_comb begin
		lim_ext = EW'(lim_q);
		if (lim_q == '0) begin
			eff_ext = EW'(1);
		end else if (lim_ext > EW'(STACK_DEPTH)) begin
			eff_ext = EW'(STACK_DEPTH);
		end else begin
			eff_ext = lim_ext;
		end
		eff_lim = eff_ext[CW-1:0];
	end

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign sp_m2    = sp_q - CW'(2);
	assign top_prec = i2p_pkg::prec_of(rd_data);
	assign c_prec   = i2p_pkg::prec_of(c_q);
	assign out_free = !out_valid_q || out_ready;
	assign can_emit = !hold_v_q || out_free;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// sequencer: dispatch, scan, settle, pop and finish
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		st_d    = st_q;
		cnt_d   = cnt_q;
		paren_d = paren_q;
		sp_d    = sp_q;
		rd_addr = cnt_m1[AW-1:0];
		we      = 1'b0;
		emit    = 1'b0;
		emit_c  = rd_data;
		fin     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				mode_d = PM_FLUSH;
				st_d   = i2p_pkg::ST_OK;
				if (i2p_pkg::is_letter(c_q)) begin
					emit    = 1'b1;
					emit_c  = c_q;
					state_d = end_q ? S_POP : S_FIN;
				end else if (c_q == i2p_pkg::CH_LPAR) begin
					if (cnt_q < eff_lim) begin
						we      = 1'b1;
						cnt_d   = cnt_q + CW'(1);
						paren_d = paren_q + CW'(1);
					end else begin
						st_d = i2p_pkg::ST_FULL;
					end
					state_d = end_q ? S_SETTLE : S_FIN;
				end else if (c_q == i2p_pkg::CH_RPAR) begin
					st_d    = (paren_q == '0) ? i2p_pkg::ST_UNMATCHED : i2p_pkg::ST_OK;
					mode_d  = PM_RPAR;
					state_d = S_POP;
				end else if (c_prec != 2'd0) begin
					mode_d = PM_OP;
					if (cnt_q < eff_lim) begin
						state_d = S_POP;
					end else begin
						sp_d    = cnt_q;
						state_d = S_SCAN;
					end
				end else begin
					st_d    = i2p_pkg::ST_INVALID;
					state_d = end_q ? S_POP : S_FIN;
				end
			end
			S_SCAN: begin
				// find where popping would stop to know whether the push fits
				if ((sp_q != '0) && (top_prec >= c_prec)) begin
					sp_d    = sp_q - CW'(1);
					rd_addr = sp_m2[AW-1:0];
				end else begin
					st_d    = (sp_q >= eff_lim) ? i2p_pkg::ST_FULL : i2p_pkg::ST_OK;
					state_d = S_POP;
				end
			end
			S_SETTLE: begin
				state_d = S_POP;
			end
			S_POP: begin
				case (mode_q)
					PM_OP: begin
						if ((cnt_q != '0) && (top_prec >= c_prec)) begin
							if (can_emit) begin
								emit    = 1'b1;
								cnt_d   = cnt_m1;
								rd_addr = cnt_m2[AW-1:0];
							end
						end else begin
							if (st_q == i2p_pkg::ST_OK) begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
							end
							mode_d  = PM_FLUSH;
							state_d = end_q ? S_SETTLE : S_FIN;
						end
					end
					PM_RPAR: begin
						if (cnt_q == '0) begin
							mode_d  = PM_FLUSH;
							state_d = end_q ? S_POP : S_FIN;
						end else if (rd_data == i2p_pkg::CH_LPAR) begin
							cnt_d   = cnt_m1;
							paren_d = paren_q - CW'(1);
							rd_addr = cnt_m2[AW-1:0];
							mode_d  = PM_FLUSH;
							state_d = end_q ? S_POP : S_FIN;
						end else if (can_emit) begin
							emit    = 1'b1;
							cnt_d   = cnt_m1;
							rd_addr = cnt_m2[AW-1:0];
						end
					end
					default: begin
						// flush: open parentheses are dropped silently
						if (cnt_q == '0) begin
							paren_d = '0;
							state_d = S_FIN;
						end else if (rd_data == i2p_pkg::CH_LPAR) begin
							cnt_d   = cnt_m1;
							paren_d = paren_q - CW'(1);
							rd_addr = cnt_m2[AW-1:0];
						end else if (can_emit) begin
							emit    = 1'b1;
							cnt_d   = cnt_m1;
							rd_addr = cnt_m2[AW-1:0];
						end
					end
				endcase
			end
			S_FIN: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= PM_FLUSH;
			st_q     <= i2p_pkg::ST_OK;
			cnt_q    <= '0;
			paren_q  <= '0;
			sp_q     <= '0;
			lim_q    <= i2p_pkg::LIMIT_RESET;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			st_q    <= st_d;
			cnt_q   <= cnt_d;
			paren_q <= paren_d;
			sp_q    <= sp_d;
			if (cfg_valid) begin
				lim_q <= cfg_data;
			end
			if (fin) begin
				hold_v_q <= 1'b0;
			end else if (emit) begin
				hold_v_q <= 1'b1;
			end
		end
	end

	// accepted item and held character
	always_ff @(posedge clk) begin
		if (in_acc) begin
			c_q   <= in_char;
			end_q <= end_of_expr;
		end
		if (emit) begin
			hold_q <= emit_c;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin || (emit && hold_v_q)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: the held character moves out when the next arrives or the item finishes
	always_ff @(posedge clk) begin
		if (fin) begin
			out_char_q   <= hold_v_q ? hold_q : '0;
			char_valid_q <= hold_v_q;
			last_q       <= 1'b1;
			status_q     <= st_q;
			done_q       <= end_q;
		end else if (emit && hold_v_q) begin
			out_char_q   <= hold_q;
			char_valid_q <= 1'b1;
			last_q       <= 1'b0;
			status_q     <= st_q;
			done_q       <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign char_valid  = char_valid_q;
	assign last_of_run = last_q;
	assign status      = status_q;
	assign expr_done   = done_q;

	// checks
	`I2P_ASSERT(a_cnt_range, cnt_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`I2P_ASSERT(a_paren_le_cnt, paren_q <= cnt_q, "open parenthesis count beyond stack count")
	`I2P_ASSERT_IMPL(a_push_room, we, cnt_q < eff_lim, "push into a full stack")
	`I2P_ASSERT_IMPL(a_idle_no_hold, in_ready, !hold_v_q, "character left behind at idle")

endmodule

### tb/tb_infix_to_postfix_converter.sv
// self-checking testbench of the infix to postfix converter with a shunting-yard predictor
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter;

	localparam int CLK_PERIOD   = 20;
	localparam int DEPTH        = i2p_pkg::STACK_DEPTH_DEF;
	localparam int IDLE_PCT     = 12;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 48;
	localparam int PHASE_CHARS  = 36;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [i2p_pkg::CHAR_W-1:0] ch;
		logic                       eoe;
	} char_item_t;

	typedef struct packed {
		logic [i2p_pkg::CHAR_W-1:0] ch;
		logic                       ch_vld;
		logic                       last;
		i2p_pkg::status_t           st;
		logic                       done;
	} postfix_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_valid   = 1'b0;
	logic                        cfg_ready;
	logic [i2p_pkg::LIMIT_W-1:0] cfg_data    = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic [i2p_pkg::CHAR_W-1:0]  in_char     = '0;
	logic                        end_of_expr = 1'b0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic [i2p_pkg::CHAR_W-1:0]  out_char;
	logic                        char_valid;
	logic                        last_of_run;
	logic [1:0]                  status;
	logic                        expr_done;

	// chars waiting to be sent and postfix results waiting to arrive
	char_item_t char_q[$];
	postfix_t   postfix_q[$];

	// predictor state: operator stack, fill level and programmed limit
	logic [i2p_pkg::CHAR_W-1:0]  op_stk [DEPTH];
	int                          stk_fill = 0;
	logic [i2p_pkg::LIMIT_W-1:0] stk_cap  = i2p_pkg::LIMIT_RESET;

	logic [i2p_pkg::CHAR_W-1:0] ops [5] = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS,
		i2p_pkg::CH_MUL, i2p_pkg::CH_DIV, i2p_pkg::CH_POW};

	int chars_in    = 0;
	int results_out = 0;
	int fail_cnt    = 0;
	int stall_cnt   = 0;
	int cfg_writes  = 0;
	int deepest     = 0;
	int st_seen [4] = '{default: 0};

	char_item_t drv_item;
	postfix_t   want;
	logic       calm;

	// window with no idling on either side
	assign calm = (chars_in >= 180) && (chars_in < 290);

	infix_to_postfix_converter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.end_of_expr (end_of_expr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.char_valid  (char_valid),
		.last_of_run (last_of_run),
		.status      (status),
		.expr_done   (expr_done)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// operator binding strength, zero for non-operators
	function automatic int op_rank(input logic [i2p_pkg::CHAR_W-1:0] c);
		case (c)
			i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: return 1;
			i2p_pkg::CH_MUL, i2p_pkg::CH_DIV:    return 2;
			i2p_pkg::CH_POW:                     return 3;
			default:                             return 0;
		endcase
	endfunction

	function automatic bit is_alpha(input logic [i2p_pkg::CHAR_W-1:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	// limit as the block applies it: 0 counts as 1, clipped to the depth
	function automatic int usable_depth();
		int lim;
		lim = int'(stk_cap);
		if (lim == 0) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		return lim;
	endfunction

	function automatic bit stack_push(input logic [i2p_pkg::CHAR_W-1:0] c);
		if (stk_fill >= usable_depth()) return 1'b0;
		op_stk[stk_fill] = c;
		stk_fill++;
		if (stk_fill > deepest) deepest = stk_fill;
		return 1'b1;
	endfunction

	// one shunting-yard step: queue the postfix results the char causes
	task automatic shunt_char(input logic [i2p_pkg::CHAR_W-1:0] c, input logic eoe);
		logic [i2p_pkg::CHAR_W-1:0] emit [$];
		logic [i2p_pkg::CHAR_W-1:0] top;
		i2p_pkg::status_t           st;
		postfix_t                   res;
		bit                         found;
		int                         rank;
		st    = i2p_pkg::ST_OK;
		found = 1'b0;
		rank  = op_rank(c);
		if (is_alpha(c)) begin
			emit.push_back(c);
		end else if (c == i2p_pkg::CH_LPAR) begin
			if (!stack_push(c)) st = i2p_pkg::ST_FULL;
		end else if (c == i2p_pkg::CH_RPAR) begin
			while (stk_fill > 0 && !found) begin
				stk_fill--;
				top = op_stk[stk_fill];
				if (top == i2p_pkg::CH_LPAR) found = 1'b1;
				else emit.push_back(top);
			end
			if (!found) st = i2p_pkg::ST_UNMATCHED;
		end else if (rank != 0) begin
			while (stk_fill > 0 && op_rank(op_stk[stk_fill-1]) >= rank) begin
				stk_fill--;
				emit.push_back(op_stk[stk_fill]);
			end
			if (!stack_push(c)) st = i2p_pkg::ST_FULL;
		end else begin
			st = i2p_pkg::ST_INVALID;
		end
		// flush, open parens vanish silently
		if (eoe) begin
			while (stk_fill > 0) begin
				stk_fill--;
				if (op_stk[stk_fill] != i2p_pkg::CH_LPAR) emit.push_back(op_stk[stk_fill]);
			end
		end
		st_seen[st]++;
		res.st = st;
		if (emit.size() == 0) begin
			res.ch     = '0;
			res.ch_vld = 1'b0;
			res.last   = 1'b1;
			res.done   = eoe;
			postfix_q.push_back(res);
		end else begin
			foreach (emit[k]) begin
				res.ch     = emit[k];
				res.ch_vld = 1'b1;
				res.last   = (k == emit.size() - 1);
				res.done   = eoe && (k == emit.size() - 1);
				postfix_q.push_back(res);
			end
		end
	endtask

	task automatic put_char(input logic [i2p_pkg::CHAR_W-1:0] c, input logic eoe);
		char_item_t it;
		it.ch  = c;
		it.eoe = eoe;
		char_q.push_back(it);
	endtask

	// queue a string, end flag on its last char only
	task automatic put_str(input string s, input logic eoe);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], eoe && (i == s.len() - 1));
	endtask

	function automatic logic [i2p_pkg::CHAR_W-1:0] rand_letter();
		if ($urandom_range(1)) return 8'("A" + $urandom_range(25));
		return 8'("a" + $urandom_range(25));
	endfunction

	// random expression, mostly well formed, sometimes broken or just noise
	task automatic gen_expr(output int n);
		char_item_t tok[$];
		char_item_t it;
		int         terms;
		int         open;
		int         cap;
		int         open_pct;
		int         pos;
		if ($urandom_range(9) == 0) begin
			put_char(8'($urandom_range(255)), 1'($urandom_range(1)));
			n = 1;
			return;
		end
		cap      = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : 3;
		open_pct = (cap > 3) ? 85 : 30;
		terms    = $urandom_range(6, 1);
		open     = 0;
		it.eoe   = 1'b0;
		for (int t = 0; t < terms; t++) begin
			while (open < cap && $urandom_range(99) < open_pct) begin
				it.ch = i2p_pkg::CH_LPAR;
				tok.push_back(it);
				open++;
			end
			it.ch = rand_letter();
			tok.push_back(it);
			while (open > 0 && $urandom_range(99) < 40) begin
				it.ch = i2p_pkg::CH_RPAR;
				tok.push_back(it);
				open--;
			end
			if (t != terms - 1) begin
				it.ch = ops[$urandom_range(4)];
				tok.push_back(it);
			end
		end
		repeat (open) begin
			it.ch = i2p_pkg::CH_RPAR;
			tok.push_back(it);
		end
		// break one position now and then
		if ($urandom_range(99) < 15) begin
			pos = $urandom_range(tok.size() - 1);
			case ($urandom_range(2))
				0:       tok[pos].ch = 8'($urandom_range(255));
				1:       tok[pos].ch = i2p_pkg::CH_RPAR;
				default: tok[pos].ch = i2p_pkg::CH_LPAR;
			endcase
		end
		// most expressions end, a few run on into the next one
		if ($urandom_range(9) != 0) tok[tok.size()-1].eoe = 1'b1;
		foreach (tok[i]) char_q.push_back(tok[i]);
		n = tok.size();
	endtask

	// wait until everything sent has come back, then a short pause
	task automatic settle();
		while (char_q.size() != 0 || in_valid || postfix_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [i2p_pkg::LIMIT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		stk_cap = v;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// input driver: one char item at a time, random gaps between items
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				shunt_char(in_char, end_of_expr);
				chars_in <= chars_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (char_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drv_item = char_q.pop_front();
					in_valid    <= 1'b1;
					in_char     <= drv_item.ch;
					end_of_expr <= drv_item.eoe;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each postfix item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_out <= results_out + 1;
				if (postfix_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("%0t: unexpected result char %h valid %b last %b status %0d done %b",
							$realtime, out_char, char_valid, last_of_run, status, expr_done);
				end else begin
					want = postfix_q.pop_front();
					if (out_char !== want.ch || char_valid !== want.ch_vld ||
						last_of_run !== want.last || status !== want.st ||
						expr_done !== want.done) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display({"%0t: got char %h valid %b last %b status %0d done %b, ",
								"want %h %b %b %0d %b"},
								$realtime, out_char, char_valid, last_of_run, status, expr_done,
								want.ch, want.ch_vld, want.last, want.st, want.done);
					end
				end
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles without any handshake on input, output or config
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
				$display("infix_to_postfix_converter: mismatch");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	// stimulus sequence
	initial begin
		logic [i2p_pkg::LIMIT_W-1:0] lims [8];
		int                          made;
		int                          n;
		lims = '{6'd32, 6'd1, 6'd2, 6'd3, 6'd0, 6'd63, 6'd5, 6'd16};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: all operators, letter extremes, invalid bytes, paren corner cases
		put_str("(A+b)*c-d/e^Z", 1'b1);
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b1);
		put_str("a+b)", 1'b0);
		put_str("z", 1'b1);
		put_str("(z", 1'b1);
		put_str("()", 1'b1);
		settle();

		// tiny and out of range limits
		write_limit(6'd1);
		put_str("a+b*c", 1'b1);
		put_str("((a))", 1'b1);
		settle();
		write_limit(6'd0);
		put_str("(a*b)^c", 1'b1);
		settle();
		write_limit(6'd63);
		repeat (34) put_char(i2p_pkg::CH_LPAR, 1'b0);
		put_str("a+b", 1'b1);
		settle();

		// limit dropped below the current fill mid expression
		write_limit(i2p_pkg::LIMIT_RESET);
		put_str("((((", 1'b0);
		settle();
		write_limit(6'd2);
		put_str("+)a*b", 1'b1);
		settle();

		// random phases, one limit each
		for (int ph = 0; ph < 9; ph++) begin
			write_limit((ph < 8) ? lims[ph] : 6'($urandom_range(63)));
			made = 0;
			while (made < PHASE_CHARS) begin
				gen_expr(n);
				made += n;
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (postfix_q.size() != 0) begin
			fail_cnt++;
			$display("%0d postfix results never arrived", postfix_q.size());
		end
		$display("sent %0d chars, checked %0d postfix results, %0d limit writes, deepest stack %0d",
			chars_in, results_out, cfg_writes, deepest);
		$display("status seen: ok %0d, full %0d, unmatched %0d, invalid %0d, mismatches %0d",
			st_seen[i2p_pkg::ST_OK], st_seen[i2p_pkg::ST_FULL],
			st_seen[i2p_pkg::ST_UNMATCHED], st_seen[i2p_pkg::ST_INVALID], fail_cnt);
		if (fail_cnt == 0) begin
			$display("infix_to_postfix_converter: match");
		end else begin
			$display("infix_to_postfix_converter: mismatch");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_stack_ram.sv
hw/rtl/infix_to_postfix_converter.sv
tb/tb_infix_to_postfix_converter.sv
